/* hdl/ctts_pkg.sv */
// Shared widths, constants and register codes of the cycle counter converter.
package ctts_pkg;

    localparam int CountBits   = 64;
    localparam int SecondsBits = 35;
    localparam int NsBits      = 30;
    localparam int AddrBits    = 6;
    localparam int DataBits    = 64;

    // Nanoseconds per second; fits the 30-bit divisor of the shared divider.
    localparam logic [NsBits-1:0] NsPerSec = NsBits'(1000000000);

    typedef enum logic [2:0] {
        REG_CONVERSION_MODE   = 3'd0,
        REG_CYCLES_PER_USEC   = 3'd1,
        REG_START_COUNT       = 3'd2,
        REG_SCALE_MULTIPLIER  = 3'd3,
        REG_SCALE_SHIFT       = 3'd4,
        REG_SPAN_SHIFT        = 3'd5,
        REG_SPAN_NANOSECONDS  = 3'd6,
        REG_WRAP_CHECK_ENABLE = 3'd7
    } cfg_reg_t;

endpackage

/* hdl/ctts_if.sv */
// Input and output channel interfaces of the cycle counter converter.
interface ctts_in_if;
    logic                           valid;
    logic                           ready;
    logic [ctts_pkg::CountBits-1:0] counter_value;

    modport source (output valid, output counter_value, input ready);
    modport sink   (input valid, input counter_value, output ready);
endinterface

interface ctts_out_if;
    logic                             valid;
    logic                             ready;
    logic [ctts_pkg::SecondsBits-1:0] seconds;
    logic [ctts_pkg::NsBits-1:0]      nanoseconds;
    logic                             wrapped;
    logic                             double_wrap_warning;

    modport source (output valid, output seconds, output nanoseconds, output wrapped,
                    output double_wrap_warning, input ready);
    modport sink   (input valid, input seconds, input nanoseconds, input wrapped,
                    input double_wrap_warning, output ready);
endinterface

/* hdl/cycle_counter_to_timespec.sv */
// Cycle counter reading to seconds plus nanoseconds, bit-serial datapath.
// An input beat is taken only in ST_IDLE: the next beat waits until the last result is in the output register.
// Mode 0 runs the one-bit-per-cycle shift-add multipliers, mode 1 a first pass of the shared
// restoring divider (64 steps each); both modes then run the divider again, back to back.
// A finished result waits in the output register while the next beat is taken.
// Reset (rst_n low, asynchronous) restores register defaults and clears wrap state and valids.
module cycle_counter_to_timespec #(
    parameter int COUNTER_BITS = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // APB-style configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ctts_pkg::AddrBits-1:0] paddr,
    input  logic [ctts_pkg::DataBits-1:0] pwdata,
    output logic [ctts_pkg::DataBits-1:0] prdata,
    output logic                          pready,
    // Streaming channels
    ctts_in_if.sink                       in_ch,
    ctts_out_if.source                    out_ch
);

    // Readings keep only their low COUNTER_BITS bits.
    localparam logic [63:0] CountMask = {64{1'b1}} >> (64 - COUNTER_BITS);
    localparam logic [5:0]  LastStep  = 6'd63;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_ALIGN,
        ST_ADD,
        ST_FDIV,
        ST_SCALE1,
        ST_SCALE2,
        ST_NSDIV,
        ST_FINISH
    } state_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic        conversion_mode_reg;
    logic [15:0] cycles_per_usec_reg;
    logic [63:0] start_count_reg;
    logic [63:0] scale_multiplier_reg;
    logic [5:0]  scale_shift_reg;
    logic [5:0]  span_shift_reg;
    logic [63:0] span_nanoseconds_reg;
    logic        wrap_check_enable_reg;

    ctts_pkg::cfg_reg_t cfg_sel;
    logic               cfg_write;

    // Registers sit on 8-byte boundaries; the low three address bits are ignored.
    assign cfg_sel   = ctts_pkg::cfg_reg_t'(paddr[5:3]);
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            conversion_mode_reg   <= 1'b0;
            cycles_per_usec_reg   <= 16'd1;
            start_count_reg       <= '0;
            scale_multiplier_reg  <= '0;
            scale_shift_reg       <= '0;
            span_shift_reg        <= '0;
            span_nanoseconds_reg  <= '0;
            wrap_check_enable_reg <= 1'b1;
        end
        else if (cfg_write)
        begin
            unique case (cfg_sel)
                ctts_pkg::REG_CONVERSION_MODE:   conversion_mode_reg   <= pwdata[0];
                ctts_pkg::REG_CYCLES_PER_USEC:   cycles_per_usec_reg   <= pwdata[15:0];
                ctts_pkg::REG_START_COUNT:       start_count_reg       <= pwdata;
                ctts_pkg::REG_SCALE_MULTIPLIER:  scale_multiplier_reg  <= pwdata;
                ctts_pkg::REG_SCALE_SHIFT:       scale_shift_reg       <= pwdata[5:0];
                ctts_pkg::REG_SPAN_SHIFT:        span_shift_reg        <= pwdata[5:0];
                ctts_pkg::REG_SPAN_NANOSECONDS:  span_nanoseconds_reg  <= pwdata;
                ctts_pkg::REG_WRAP_CHECK_ENABLE: wrap_check_enable_reg <= pwdata[0];
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_sel)
            ctts_pkg::REG_CONVERSION_MODE:   prdata = {63'd0, conversion_mode_reg};
            ctts_pkg::REG_CYCLES_PER_USEC:   prdata = {48'd0, cycles_per_usec_reg};
            ctts_pkg::REG_START_COUNT:       prdata = start_count_reg;
            ctts_pkg::REG_SCALE_MULTIPLIER:  prdata = scale_multiplier_reg;
            ctts_pkg::REG_SCALE_SHIFT:       prdata = {58'd0, scale_shift_reg};
            ctts_pkg::REG_SPAN_SHIFT:        prdata = {58'd0, span_shift_reg};
            ctts_pkg::REG_SPAN_NANOSECONDS:  prdata = span_nanoseconds_reg;
            ctts_pkg::REG_WRAP_CHECK_ENABLE: prdata = {63'd0, wrap_check_enable_reg};
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    state_t      state_reg;
    logic [5:0]  step_reg;

    // Shift-add multiplier for the low part: {prod_hi, prod_lo} ends as the 128-bit product.
    logic [63:0] prod_hi_reg;
    logic [63:0] prod_lo_reg;
    // Shift-add multiplier for spans * span_nanoseconds, kept modulo 2^64.
    logic [63:0] spans_reg;
    logic [63:0] span_ns_reg;
    logic [63:0] sum_reg;

    // Restoring divider: dividend shifts out of quot_reg while quotient bits shift in.
    logic [63:0]              quot_reg;
    logic [ctts_pkg::NsBits-1:0] rem_reg;
    logic [ctts_pkg::NsBits-1:0] divisor_reg;

    // Wrap state and per-item flags
    logic wrap_seen_reg;
    logic warning_given_reg;
    logic item_wrapped_reg;
    logic item_warn_reg;

    // Output register
    logic                             out_valid_reg;
    logic [ctts_pkg::SecondsBits-1:0] out_seconds_reg;
    logic [ctts_pkg::NsBits-1:0]      out_ns_reg;
    logic                             out_wrapped_reg;
    logic                             out_warn_reg;

    // ------------------------------------------------------------------
    // Combinational helpers
    // ------------------------------------------------------------------
    logic [63:0] reading;
    logic [63:0] delta;
    logic [63:0] low_mask;
    logic        below_start;
    logic        in_beat;
    logic        out_beat;

    assign reading     = in_ch.counter_value & CountMask;
    assign delta       = reading - start_count_reg;
    assign low_mask    = (64'd1 << span_shift_reg) - 64'd1;
    assign below_start = reading < start_count_reg;
    assign in_beat     = in_ch.valid && in_ch.ready;
    assign out_beat    = out_valid_reg && out_ch.ready;

    // One multiplier bit per cycle for both products.
    logic [64:0] hi_sum;
    logic [63:0] span_sum;

    assign hi_sum   = {1'b0, prod_hi_reg} + (prod_lo_reg[0] ? {1'b0, scale_multiplier_reg} : 65'd0);
    assign span_sum = sum_reg + (spans_reg[0] ? span_ns_reg : 64'd0);

    // Scaled low part: the product wraps to its low 64 bits first, then shifts right.
    logic [63:0] prod_aligned;

    assign prod_aligned = prod_lo_reg >> scale_shift_reg;

    // One quotient bit per cycle; the partial remainder stays below the divisor.
    logic [ctts_pkg::NsBits:0]   div_shifted;
    logic [ctts_pkg::NsBits+1:0] div_diff;
    logic                        div_take;

    assign div_shifted = {rem_reg, quot_reg[63]};
    assign div_diff    = {1'b0, div_shifted} - {2'b00, divisor_reg};
    assign div_take    = !div_diff[ctts_pkg::NsBits+1];

    // Wrap check on the accepted reading.
    logic wrap_set;
    logic warn_set;

    assign wrap_set = wrap_check_enable_reg && below_start && !wrap_seen_reg;
    assign warn_set = wrap_check_enable_reg && !wrap_set && wrap_seen_reg && !below_start
                      && !warning_given_reg;

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            step_reg          <= '0;
            prod_hi_reg       <= '0;
            prod_lo_reg       <= '0;
            spans_reg         <= '0;
            span_ns_reg       <= '0;
            sum_reg           <= '0;
            quot_reg          <= '0;
            rem_reg           <= '0;
            divisor_reg       <= '0;
            wrap_seen_reg     <= 1'b0;
            warning_given_reg <= 1'b0;
            item_wrapped_reg  <= 1'b0;
            item_warn_reg     <= 1'b0;
            out_valid_reg     <= 1'b0;
            out_seconds_reg   <= '0;
            out_ns_reg        <= '0;
            out_wrapped_reg   <= 1'b0;
            out_warn_reg      <= 1'b0;
        end
        else
        begin
            // Drop the output beat once taken; ST_FINISH may reload it in the same cycle.
            if (out_beat)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_beat)
                    begin
                        if (wrap_set)
                        begin
                            wrap_seen_reg <= 1'b1;
                        end
                        if (warn_set)
                        begin
                            warning_given_reg <= 1'b1;
                        end
                        item_wrapped_reg <= wrap_seen_reg || wrap_set;
                        item_warn_reg    <= warn_set;

                        prod_hi_reg <= '0;
                        prod_lo_reg <= delta & low_mask;
                        spans_reg   <= delta >> span_shift_reg;
                        span_ns_reg <= span_nanoseconds_reg;
                        sum_reg     <= '0;
                        quot_reg    <= reading;
                        rem_reg     <= '0;
                        // A zero rate divides as one.
                        divisor_reg <= (cycles_per_usec_reg == 16'd0) ? ctts_pkg::NsBits'(1)
                                       : ctts_pkg::NsBits'(cycles_per_usec_reg);
                        step_reg    <= '0;
                        state_reg   <= conversion_mode_reg ? ST_FDIV : ST_MUL;
                    end
                end

                ST_MUL:
                begin
                    prod_hi_reg <= hi_sum[64:1];
                    prod_lo_reg <= {hi_sum[0], prod_lo_reg[63:1]};
                    sum_reg     <= span_sum;
                    spans_reg   <= {1'b0, spans_reg[63:1]};
                    span_ns_reg <= {span_ns_reg[62:0], 1'b0};
                    step_reg    <= step_reg + 6'd1;
                    if (step_reg == LastStep)
                    begin
                        state_reg <= ST_ALIGN;
                    end
                end

                ST_ALIGN:
                begin
                    prod_lo_reg <= prod_aligned;
                    state_reg   <= ST_ADD;
                end

                ST_ADD:
                begin
                    quot_reg    <= sum_reg + prod_lo_reg;
                    rem_reg     <= '0;
                    divisor_reg <= ctts_pkg::NsPerSec;
                    step_reg    <= '0;
                    state_reg   <= ST_NSDIV;
                end

                ST_FDIV:
                begin
                    rem_reg  <= div_take ? div_diff[ctts_pkg::NsBits-1:0]
                                         : div_shifted[ctts_pkg::NsBits-1:0];
                    quot_reg <= {quot_reg[62:0], div_take};
                    step_reg <= step_reg + 6'd1;
                    if (step_reg == LastStep)
                    begin
                        state_reg <= ST_SCALE1;
                    end
                end

                // Microseconds to nanoseconds: q * 1000 = q*1024 - q*8 - q*16, in ST_SCALE1 and ST_SCALE2.
                ST_SCALE1:
                begin
                    sum_reg   <= {quot_reg[53:0], 10'd0} - {quot_reg[60:0], 3'd0};
                    state_reg <= ST_SCALE2;
                end

                ST_SCALE2:
                begin
                    quot_reg    <= sum_reg - {quot_reg[59:0], 4'd0};
                    rem_reg     <= '0;
                    divisor_reg <= ctts_pkg::NsPerSec;
                    step_reg    <= '0;
                    state_reg   <= ST_NSDIV;
                end

                ST_NSDIV:
                begin
                    rem_reg  <= div_take ? div_diff[ctts_pkg::NsBits-1:0]
                                         : div_shifted[ctts_pkg::NsBits-1:0];
                    quot_reg <= {quot_reg[62:0], div_take};
                    step_reg <= step_reg + 6'd1;
                    if (step_reg == LastStep)
                    begin
                        state_reg <= ST_FINISH;
                    end
                end

                // Hold here until the output register is free.
                ST_FINISH:
                begin
                    if (!out_valid_reg || out_ch.ready)
                    begin
                        out_valid_reg   <= 1'b1;
                        out_seconds_reg <= quot_reg[ctts_pkg::SecondsBits-1:0];
                        out_ns_reg      <= rem_reg;
                        out_wrapped_reg <= item_wrapped_reg;
                        out_warn_reg    <= item_warn_reg;
                        state_reg       <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Channel outputs
    // ------------------------------------------------------------------
    assign in_ch.ready                = (state_reg == ST_IDLE);
    assign out_ch.valid               = out_valid_reg;
    assign out_ch.seconds             = out_seconds_reg;
    assign out_ch.nanoseconds         = out_ns_reg;
    assign out_ch.wrapped             = out_wrapped_reg;
    assign out_ch.double_wrap_warning = out_warn_reg;

endmodule
